[sv/bsrp_pkg.sv]
// Shared constants and types for the box screen rectangle projection.
// Fixed-point widths, clip depth, pixel limits and register indexes.
// Used by bsrp_div and box_screen_rect_projection.
package bsrp_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int ROT_FRAC = 14;
	localparam int CW = 24;
	localparam int HW = 22;
	localparam int RWORD = 16;
	localparam int RW = CW + 1;
	localparam int CRW = RW + 1;
	localparam int PW = RWORD + CRW;
	localparam int TW = PW + 2;
	localparam int FW = 20;
	localparam int LO_W = TW / 2;
	localparam int HI_W = TW - LO_W;
	localparam int PPW = HI_W + FW;
	localparam int NW = TW + FW;
	localparam int QW = 28;
	localparam int PXW = QW + 1;
	localparam int SW = PXW + 1;
	localparam int OW = 22;
	localparam int CFG_W = 48;
	localparam int IDX_W = 3;
	localparam int DIV_LAT = QW + 2;
	localparam int PRE_LAT = 6;
	localparam int LAT = PRE_LAT + DIV_LAT + 3;

	localparam longint CLIP_DEPTH =
		((longint'(1) << (COORD_FRAC_BITS + ROT_FRAC)) + 5) / 10;
	localparam logic [TW-1:0] CLIP = TW'(CLIP_DEPTH);
	localparam logic [QW-1:0] PIX_LIMIT = QW'(256000000);
	localparam logic signed [SW-1:0] MIN_SPAN = SW'(1024);
	localparam logic [FW-1:0] FOCAL_RESET = FW'(256);

	localparam logic [IDX_W-1:0] REG_ROT0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_CAMX = 3'd3;
	localparam logic [IDX_W-1:0] REG_CAMY = 3'd4;
	localparam logic [IDX_W-1:0] REG_CAMZ = 3'd5;
	localparam logic [IDX_W-1:0] REG_FOCAL = 3'd6;
	localparam logic [IDX_W-1:0] REG_CENTRE = 3'd7;

	typedef logic signed [PXW-1:0] px_t;
	typedef logic [NW-1:0] num_t;
	typedef logic [TW-1:0] den_t;

endpackage

[sv/box_screen_rect_projection.sv]
// Throughput: one beat per cycle unless the output stalls; the 30-stage divider lanes set the depth.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears valid bits and sets the
// registers to identity-free defaults: zero rotation, camera and centre, focal 256.
module box_screen_rect_projection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bsrp_pkg::IDX_W-1:0]         cfg_idx,
	input  logic [bsrp_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// box_x, box_y, box_z, half_x, half_y, half_z, zero pad
	input  logic [143:0]                       s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// rect_min_x, rect_min_y, rect_max_x, rect_max_y
	output logic [87:0]                        m_tdata,
	// visible
	output logic                               m_tuser
);
	import bsrp_pkg::*;

	logic [CFG_W-1:0] rot_q [0:2];
	logic signed [CW-1:0] cam_q [0:2];
	logic [FW-1:0] focal_q;
	logic [31:0] centre_q;

	logic adv;
	logic [LAT:1] vld_s;

	logic signed [CW-1:0] box_in [0:2];
	logic [HW-1:0] half_in [0:2];

	logic signed [RW-1:0] rel_s1 [0:2];
	logic [HW-1:0] half_s1 [0:2];
	logic signed [CRW-1:0] c_d [0:7][0:2];
	logic signed [CRW-1:0] c_s2 [0:7][0:2];
	logic signed [PW-1:0] p_s3 [0:7][0:2][0:2];
	logic [TW-1:0] mag_s4 [0:7][0:1];
	logic neg_s4 [0:7][0:1];
	den_t d_s4 [0:7];
	logic [PPW-1:0] hi_s5 [0:7][0:1];
	logic [PPW-1:0] lo_s5 [0:7][0:1];
	logic neg_s5 [0:7][0:1];
	den_t d_s5 [0:7];
	num_t n_s6 [0:7][0:1];
	logic neg_s6 [0:7][0:1];
	den_t d_s6 [0:7];
	px_t px_d [0:7][0:1];

	px_t min_s37 [0:1][0:1];
	px_t max_s37 [0:1][0:1];
	px_t min_s38 [0:1];
	px_t max_s38 [0:1];
	logic signed [SW-1:0] span_s38 [0:1];
	logic vis_s39;
	logic [OW-1:0] rect_s39 [0:3];

	function automatic logic [OW-1:0] to_pixel(input px_t v, input logic [15:0] c);
		logic signed [PXW:0] b;
		logic signed [PXW:0] r;
		b = (PXW+1)'(v) + (PXW+1)'(128);
		if (b < 0) begin
			b = b + (PXW+1)'(255);
		end
		r = b >>> 8;
		return OW'({1'b0, c}) + OW'(r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= '0;
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			focal_q <= FOCAL_RESET;
			centre_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROT0: rot_q[0] <= cfg_data;
				REG_ROT1: rot_q[1] <= cfg_data;
				REG_ROT2: rot_q[2] <= cfg_data;
				REG_CAMX: cam_q[0] <= cfg_data[CW-1:0];
				REG_CAMY: cam_q[1] <= cfg_data[CW-1:0];
				REG_CAMZ: cam_q[2] <= cfg_data[CW-1:0];
				REG_FOCAL: focal_q <= cfg_data[FW-1:0];
				REG_CENTRE: centre_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign adv = !vld_s[LAT] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	assign box_in[0] = s_tdata[23:0];
	assign box_in[1] = s_tdata[47:24];
	assign box_in[2] = s_tdata[71:48];
	assign half_in[0] = s_tdata[93:72];
	assign half_in[1] = s_tdata[115:94];
	assign half_in[2] = s_tdata[137:116];

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			for (int a = 0; a < 3; a++) begin
				if (k[2-a]) begin
					c_d[k][a] = CRW'(rel_s1[a]) + CRW'(half_s1[a]);
				end else begin
					c_d[k][a] = CRW'(rel_s1[a]) - CRW'(half_s1[a]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				rel_s1[a] <= RW'(box_in[a]) - RW'(cam_q[a]);
				half_s1[a] <= half_in[a];
			end
			c_s2 <= c_d;
			for (int k = 0; k < 8; k++) begin
				for (int r = 0; r < 3; r++) begin
					for (int a = 0; a < 3; a++) begin
						p_s3[k][r][a] <= PW'($signed(rot_q[r][16*a +: 16])) * PW'(c_s2[k][a]);
					end
				end
			end
			for (int k = 0; k < 8; k++) begin
				logic signed [TW-1:0] t [0:2];
				logic signed [TW-1:0] nd;
				for (int r = 0; r < 3; r++) begin
					t[r] = TW'(p_s3[k][r][0]) + TW'(p_s3[k][r][1]) + TW'(p_s3[k][r][2]);
				end
				for (int r = 0; r < 2; r++) begin
					neg_s4[k][r] <= t[r][TW-1];
					mag_s4[k][r] <= t[r][TW-1] ? TW'(-t[r]) : TW'(t[r]);
				end
				nd = -t[2];
				d_s4[k] <= (nd > $signed(CLIP)) ? TW'(nd) : CLIP;
			end
			for (int k = 0; k < 8; k++) begin
				for (int r = 0; r < 2; r++) begin
					hi_s5[k][r] <= PPW'(mag_s4[k][r][TW-1:LO_W]) * PPW'(focal_q);
					lo_s5[k][r] <= PPW'(mag_s4[k][r][LO_W-1:0]) * PPW'(focal_q);
					neg_s5[k][r] <= neg_s4[k][r];
					n_s6[k][r] <= (NW'(hi_s5[k][r]) << LO_W) + NW'(lo_s5[k][r]);
					neg_s6[k][r] <= neg_s5[k][r];
				end
				d_s5[k] <= d_s4[k];
				d_s6[k] <= d_s5[k];
			end
		end
	end

	for (genvar k = 0; k < 8; k++) begin : g_corner
		for (genvar r = 0; r < 2; r++) begin : g_axis
			bsrp_div u_div (
				.clk (clk),
				.en  (adv),
				.neg (neg_s6[k][r]),
				.num (n_s6[k][r]),
				.den (d_s6[k]),
				.px  (px_d[k][r])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int h = 0; h < 2; h++) begin
				for (int r = 0; r < 2; r++) begin
					px_t a0, a1, b0, b1;
					a0 = (px_d[4*h][r] < px_d[4*h+1][r]) ? px_d[4*h][r] : px_d[4*h+1][r];
					a1 = (px_d[4*h+2][r] < px_d[4*h+3][r]) ? px_d[4*h+2][r] : px_d[4*h+3][r];
					b0 = (px_d[4*h][r] > px_d[4*h+1][r]) ? px_d[4*h][r] : px_d[4*h+1][r];
					b1 = (px_d[4*h+2][r] > px_d[4*h+3][r]) ? px_d[4*h+2][r] : px_d[4*h+3][r];
					min_s37[h][r] <= (a0 < a1) ? a0 : a1;
					max_s37[h][r] <= (b0 > b1) ? b0 : b1;
				end
			end
			for (int r = 0; r < 2; r++) begin
				px_t lo, hi;
				lo = (min_s37[0][r] < min_s37[1][r]) ? min_s37[0][r] : min_s37[1][r];
				hi = (max_s37[0][r] > max_s37[1][r]) ? max_s37[0][r] : max_s37[1][r];
				min_s38[r] <= lo;
				max_s38[r] <= hi;
				span_s38[r] <= SW'(hi) - SW'(lo);
			end
			begin
				logic signed [SW-1:0] lim;
				logic ok;
				lim = SW'({focal_q, 2'b00});
				ok = span_s38[0] >= MIN_SPAN && span_s38[0] <= lim &&
					span_s38[1] >= MIN_SPAN && span_s38[1] <= lim;
				vis_s39 <= ok;
				rect_s39[0] <= ok ? to_pixel(min_s38[0], centre_q[15:0]) : '0;
				rect_s39[1] <= ok ? to_pixel(min_s38[1], centre_q[31:16]) : '0;
				rect_s39[2] <= ok ? to_pixel(max_s38[0], centre_q[15:0]) : '0;
				rect_s39[3] <= ok ? to_pixel(max_s38[1], centre_q[31:16]) : '0;
			end
		end
	end

	assign m_tuser = vis_s39;
	assign m_tdata = {rect_s39[3], rect_s39[2], rect_s39[1], rect_s39[0]};

`ifndef SYNTHESIS
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("hidden box carries a non-zero rectangle");
	a_rect_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			$signed(m_tdata[21:0]) <= $signed(m_tdata[65:44]) &&
			$signed(m_tdata[43:22]) <= $signed(m_tdata[87:66]))
		else $error("rectangle bounds out of order");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during a stall");
`endif

endmodule

[sv/bsrp_div.sv]
// Pipelined restoring divider: one quotient bit per stage, then clamp and sign.
// Gives sign * min(num / den, pixel limit), truncated toward zero.
// Depends on bsrp_pkg.
module bsrp_div (
	input  logic           clk,
	input  logic           en,
	input  logic           neg,
	input  bsrp_pkg::num_t num,
	input  bsrp_pkg::den_t den,
	output bsrp_pkg::px_t  px
);
	import bsrp_pkg::*;

	localparam int XW = TW + QW;

	num_t rem_s [0:QW];
	den_t den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic sat_s [0:QW];
	logic neg_s [0:QW];
	px_t px_s;
	logic ovf;
	logic [QW-1:0] mag;

	assign ovf = XW'(num) >= (XW'(den) << QW);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			sat_s[0] <= ovf;
			neg_s[0] <= neg;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_bit
		logic [XW-1:0] trial;
		logic take;
		assign trial = XW'(den_s[j-1]) << (QW - j);
		assign take = XW'(rem_s[j-1]) >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? rem_s[j-1] - NW'(trial) : rem_s[j-1];
				quo_s[j] <= quo_s[j-1] | (take ? (QW'(1) << (QW - j)) : QW'(0));
				den_s[j] <= den_s[j-1];
				sat_s[j] <= sat_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	assign mag = (sat_s[QW] || quo_s[QW] > PIX_LIMIT) ? PIX_LIMIT : quo_s[QW];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s <= neg_s[QW] ? -px_t'({1'b0, mag}) : px_t'({1'b0, mag});
		end
	end

	assign px = px_s;

endmodule

[tb/bsrp_checker.sv]
// Checker for box_screen_rect_projection: predicts each result rectangle from
// the accepted box beats and the register writes, and compares output beats.
// Depends on bsrp_pkg for register indexes and widths.
`timescale 1ns / 1ps

module bsrp_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsrp_pkg::IDX_W-1:0] cfg_idx,
	input  logic [bsrp_pkg::CFG_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [143:0]               s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [87:0]                m_tdata,
	input  logic                       m_tuser,
	output int                         fail_count,
	output int                         pending
);
	import bsrp_pkg::*;

	typedef struct packed {
		logic        visible;
		logic [21:0] min_x;
		logic [21:0] min_y;
		logic [21:0] max_x;
		logic [21:0] max_y;
	} rect_t;

	logic [47:0] rot [3];
	longint      cam [3];
	longint      focal;
	logic [31:0] centre;
	rect_t       rect_q[$];

	function automatic longint rot_coef(int r, int a);
		logic signed [15:0] w;
		w = rot[r][16*a +: 16];
		return longint'(w);
	endfunction

	function automatic longint to_pixels(longint num, longint d);
		longint q;
		q = (num * focal) / d;
		if (q > 256000000) q = 256000000;
		if (q < -256000000) q = -256000000;
		return q;
	endfunction

	function automatic rect_t project_box(logic [143:0] b);
		longint rel [3];
		longint hs [3];
		longint c [3];
		longint t [3];
		longint d, px, py, mnx, mny, mxx, mxy, sx, sy, cx, cy;
		rect_t res;
		for (int a = 0; a < 3; a++) begin
			rel[a] = longint'($signed(b[24*a +: 24])) - cam[a];
			hs[a] = longint'(b[72 + 22*a +: 22]);
		end
		for (int k = 0; k < 8; k++) begin
			c[0] = k[2] ? rel[0] + hs[0] : rel[0] - hs[0];
			c[1] = k[1] ? rel[1] + hs[1] : rel[1] - hs[1];
			c[2] = k[0] ? rel[2] + hs[2] : rel[2] - hs[2];
			for (int r = 0; r < 3; r++) begin
				t[r] = 0;
				for (int a = 0; a < 3; a++) t[r] += rot_coef(r, a) * c[a];
			end
			d = -t[2];
			if (d < CLIP_DEPTH) d = CLIP_DEPTH;
			px = to_pixels(t[0], d);
			py = to_pixels(t[1], d);
			if (k == 0 || px < mnx) mnx = px;
			if (k == 0 || px > mxx) mxx = px;
			if (k == 0 || py < mny) mny = py;
			if (k == 0 || py > mxy) mxy = py;
		end
		sx = mxx - mnx;
		sy = mxy - mny;
		cx = longint'(centre[15:0]);
		cy = longint'(centre[31:16]);
		res = '0;
		if (!(sx < 1024 || sx > 4 * focal || sy < 1024 || sy > 4 * focal)) begin
			res.visible = 1'b1;
			res.min_x = 22'(cx + (mnx + 128) / 256);
			res.min_y = 22'(cy + (mny + 128) / 256);
			res.max_x = 22'(cx + (mxx + 128) / 256);
			res.max_y = 22'(cy + (mxy + 128) / 256);
		end
		return res;
	endfunction

	assign pending = rect_q.size();

	always @(posedge clk or negedge arst_n) begin
		rect_t e;
		if (!arst_n) begin
			rot[0] <= '0; rot[1] <= '0; rot[2] <= '0;
			cam[0] <= 0; cam[1] <= 0; cam[2] <= 0;
			focal <= 256;
			centre <= '0;
			fail_count <= 0;
			rect_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (rect_q.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = rect_q.pop_front();
					if (m_tuser !== e.visible || m_tdata[21:0] !== e.min_x ||
						m_tdata[43:22] !== e.min_y || m_tdata[65:44] !== e.max_x ||
						m_tdata[87:66] !== e.max_y) begin
						fail_count <= fail_count + 1;
						if (m_tuser !== e.visible)
							$error("visible: expected %0d, got %0d", e.visible, m_tuser);
						if (m_tdata[21:0] !== e.min_x)
							$error("rect_min_x: expected %0d, got %0d",
								$signed(e.min_x), $signed(m_tdata[21:0]));
						if (m_tdata[43:22] !== e.min_y)
							$error("rect_min_y: expected %0d, got %0d",
								$signed(e.min_y), $signed(m_tdata[43:22]));
						if (m_tdata[65:44] !== e.max_x)
							$error("rect_max_x: expected %0d, got %0d",
								$signed(e.max_x), $signed(m_tdata[65:44]));
						if (m_tdata[87:66] !== e.max_y)
							$error("rect_max_y: expected %0d, got %0d",
								$signed(e.max_y), $signed(m_tdata[87:66]));
					end
				end
			end
			if (s_tvalid && s_tready) rect_q.push_back(project_box(s_tdata));
			if (cfg_we) begin
				case (cfg_idx)
					REG_ROT0:   rot[0] <= cfg_data;
					REG_ROT1:   rot[1] <= cfg_data;
					REG_ROT2:   rot[2] <= cfg_data;
					REG_CAMX:   cam[0] <= longint'($signed(cfg_data[23:0]));
					REG_CAMY:   cam[1] <= longint'($signed(cfg_data[23:0]));
					REG_CAMZ:   cam[2] <= longint'($signed(cfg_data[23:0]));
					REG_FOCAL:  focal <= longint'(cfg_data[19:0]);
					REG_CENTRE: centre <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end
endmodule

[tb/tb_box_screen_rect_projection.sv]
// Top of the box_screen_rect_projection testbench: clock, reset, register
// settings, box stimulus with idle phases and back-pressure, and verdict.
// Depends on bsrp_pkg, the block and bsrp_checker.
`timescale 1ns / 1ps

module tb_box_screen_rect_projection;
	import bsrp_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_idx = '0;
	logic [47:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;
	logic         m_tuser;
	int           fail_count;
	int           pending;
	int           send_idle = 0;
	int           recv_stall = 0;
	int           hold_cycles = 0;
	int           cur_phase = -1;
	logic         hold_done = 1'b0;
	int           quiet = 0;

	always #6 clk = ~clk;

	box_screen_rect_projection u_top (.*);

	bsrp_checker u_chk (.*);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("tb_box_screen_rect_projection: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (cur_phase == 4 && !hold_done) begin
			hold_cycles <= 300;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 5) @(negedge clk);
	endtask

	task automatic send_box(logic [23:0] bx, by, bz, logic [21:0] hx, hy, hz);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {12'd0, hz, hy, hx, bz, by, bx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [47:0] rot_pack(int a, int b, int c);
		return {16'(c), 16'(b), 16'(a)};
	endfunction

	task automatic camera_setup(int mode);
		case (mode)
			0: begin
				write_reg(REG_ROT0, rot_pack(16384, 0, 0));
				write_reg(REG_ROT1, rot_pack(0, 16384, 0));
				write_reg(REG_ROT2, rot_pack(0, 0, 16384));
				write_reg(REG_CAMX, 48'(0));
				write_reg(REG_CAMY, 48'(0));
				write_reg(REG_CAMZ, 48'(24'(2560)));
				write_reg(REG_FOCAL, 48'(256 * 200));
				write_reg(REG_CENTRE, 48'({16'd300, 16'd400}));
			end
			1: begin
				write_reg(REG_ROT0, rot_pack(11585, 0, -11585));
				write_reg(REG_ROT1, rot_pack(0, 16384, 0));
				write_reg(REG_ROT2, rot_pack(11585, 0, 11585));
				write_reg(REG_CAMX, 48'(24'(-1000)));
				write_reg(REG_CAMY, 48'(24'(500)));
				write_reg(REG_CAMZ, 48'(24'(5000)));
				write_reg(REG_FOCAL, 48'(20'hFFFFF));
				write_reg(REG_CENTRE, 48'(32'hFFFF_FFFF));
			end
			2: begin
				write_reg(REG_ROT0, 48'hFFFF_FFFF_FFFF);
				write_reg(REG_ROT1, rot_pack(-32768, 32767, -32768));
				write_reg(REG_ROT2, rot_pack(32767, -32768, 32767));
				write_reg(REG_CAMX, 48'h7F_FFFF);
				write_reg(REG_CAMY, 48'h80_0000);
				write_reg(REG_CAMZ, 48'hFF80_0000);
				write_reg(REG_FOCAL, 48'(1));
				write_reg(REG_CENTRE, 48'(0));
			end
			default: begin
				for (int i = 0; i < 3; i++) write_reg(3'(i), 48'({$urandom, $urandom}));
				for (int i = 3; i < 6; i++) write_reg(3'(i), 48'($urandom));
				write_reg(REG_FOCAL, 48'($urandom_range(1, 20'hFFFFF)));
				write_reg(REG_CENTRE, 48'($urandom));
			end
		endcase
	endtask

	task automatic random_box();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			send_box(24'($signed($urandom_range(4000)) - 2000),
				24'($signed($urandom_range(4000)) - 2000),
				24'($signed($urandom_range(12000)) - 9000),
				22'($urandom_range(2000)), 22'($urandom_range(2000)),
				22'($urandom_range(2000)));
		else
			send_box(24'($urandom), 24'($urandom), 24'($urandom),
				22'($urandom), 22'($urandom), 22'($urandom));
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		send_box(24'(0), 24'(0), 24'(-2560), 22'(256), 22'(256), 22'(256));
		drain();
		camera_setup(0);
		send_box(24'(0), 24'(0), 24'(-2560), 22'(256), 22'(256), 22'(256));
		send_box(24'(0), 24'(0), 24'(-2560), 22'(0), 22'(0), 22'(0));
		send_box(24'(0), 24'(0), 24'(2560), 22'(512), 22'(512), 22'(512));
		send_box(24'(0), 24'(0), 24'(0), 22'(256), 22'(256), 22'(256));
		send_box(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 22'h3F_FFFF, 22'h3F_FFFF,
			22'h3F_FFFF);
		send_box(24'h80_0000, 24'h80_0000, 24'h80_0000, 22'h3F_FFFF, 22'(0),
			22'h3F_FFFF);
		send_box(24'(-300), 24'(200), 24'(-100000), 22'(5), 22'(7), 22'(3));
		send_box(24'(-300), 24'(200), 24'(-20000), 22'(256), 22'(128), 22'(64));
		drain();
		camera_setup(2);
		send_box(24'h7F_FFFF, 24'(0), 24'h80_0000, 22'h3F_FFFF, 22'h3F_FFFF,
			22'h3F_FFFF);
		send_box(24'(0), 24'(0), 24'(0), 22'h3F_FFFF, 22'h3F_FFFF, 22'h3F_FFFF);
		drain();
		camera_setup(1);
		send_box(24'(0), 24'(0), 24'(0), 22'(256), 22'(256), 22'(256));
		send_box(24'(-5000), 24'(0), 24'(0), 22'(2000), 22'(2000), 22'(2000));
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			camera_setup(ph % 4 == 3 ? 3 : ph % 2);
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 30 : 55) : 0;
			recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 30 : 55) : 0;
			cur_phase = ph;
			for (int n = 0; n < 66; n++) random_box();
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		if (fail_count == 0) $display("tb_box_screen_rect_projection: clean");
		else $display("tb_box_screen_rect_projection: errors");
		$finish;
	end
endmodule
